@@ sv/frc_pkg.sv @@
package frc_pkg;

	// Parameter defaults
	localparam int DUTY_BITS_DEF = 8;
	localparam int ADC_BITS_DEF  = 10;

	// Configuration port geometry and register reset values
	localparam int        CFG_ADDR_W    = 3;
	localparam int        CFG_DATA_W    = 32;
	localparam logic [7:0] DUTY_LIMIT_RST = 8'd255;
	localparam logic [7:0] STEP_SIZE_RST = 8'd13;

	// Register index, taken from the word address
	localparam logic REG_DUTY_LIMIT = 1'b0;
	localparam logic REG_STEP_SIZE  = 1'b1;

	// Vehicle state codes
	localparam logic [2:0] VS_LOW_VOLT  = 3'd0;
	localparam logic [2:0] VS_HV_ENABLE = 3'd1;
	localparam logic [2:0] VS_READY     = 3'd2;
	localparam logic [2:0] VS_ERROR     = 3'd3;

	typedef enum logic [1:0] {
		MODE_OFF = 2'd0,
		MODE_ON  = 2'd1,
		MODE_ERR = 2'd2
	} fan_mode_t;

	typedef enum logic [1:0] {
		ST_OFF  = 2'd0,
		ST_RAMP = 2'd1,
		ST_ON   = 2'd2,
		ST_ERR  = 2'd3
	} fan_status_t;

	typedef struct packed {
		logic [7:0] step_size;
		logic [7:0] duty_limit;
	} frc_cfg_t;

	// Result item; last member sits in the lowest bits
	typedef struct packed {
		fan_status_t fan3_status;
		fan_status_t fan2_status;
		fan_status_t fan1_status;
		fan_mode_t   fan_mode;
		logic [7:0]  pwm_duty;
	} frc_result_t;

	localparam int RES_W = $bits(frc_result_t);

	// Decode the fan mode from present and requested vehicle state
	function automatic fan_mode_t decode_mode(input logic [2:0] present,
			input logic [2:0] request, input fan_mode_t kept);
		logic req_run;
		req_run = (request == VS_HV_ENABLE) || (request == VS_READY);
		if (present == VS_LOW_VOLT) begin
			if (request == VS_LOW_VOLT)
				return MODE_OFF;
			else if (req_run)
				return MODE_ON;
			else
				return kept;
		end else if (present == VS_HV_ENABLE || present == VS_READY) begin
			return req_run ? MODE_ON : MODE_OFF;
		end else if (present == VS_ERROR) begin
			return MODE_ERR;
		end else begin
			return MODE_OFF;
		end
	endfunction

endpackage

@@ sv/frc_cfg_regs.sv @@
module frc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [frc_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [frc_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [frc_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	output frc_pkg::frc_cfg_t                cfg
);
	import frc_pkg::*;

	logic       wr_en;
	logic       reg_idx;
	logic [7:0] duty_limit_q;
	logic [7:0] step_size_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2];

	// Write on the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_limit_q <= DUTY_LIMIT_RST;
			step_size_q  <= STEP_SIZE_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DUTY_LIMIT: duty_limit_q <= pwdata[7:0];
				REG_STEP_SIZE:  step_size_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_DUTY_LIMIT: prdata = CFG_DATA_W'(duty_limit_q);
			REG_STEP_SIZE:  prdata = CFG_DATA_W'(step_size_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.duty_limit = duty_limit_q;
	assign cfg.step_size  = step_size_q;

endmodule

@@ sv/frc_tick_unit.sv @@
module frc_tick_unit #(
	parameter int DUTY_BITS = frc_pkg::DUTY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic [2:0]           vehicle_state,
	input  logic [2:0]           requested_state,
	input  logic [2:0]           cur_zero,
	input  frc_pkg::frc_cfg_t    cfg,
	output frc_pkg::frc_result_t res
);
	import frc_pkg::*;

	localparam int CW = ((DUTY_BITS > 8) ? DUTY_BITS : 8) + 1;

	fan_mode_t             mode_q;
	fan_mode_t             mode_d;
	logic [DUTY_BITS-1:0]  duty_q;
	logic [DUTY_BITS-1:0]  duty_d;
	logic [DUTY_BITS-1:0]  maxd;
	logic [CW-1:0]         gap;
	logic                  snap;
	fan_status_t           st;

	// Next mode and duty for this tick
	always_comb begin
		mode_d = decode_mode(vehicle_state, requested_state, mode_q);
		maxd   = DUTY_BITS'(cfg.duty_limit);
		gap    = CW'(maxd) - CW'(duty_q);
		snap   = (duty_q >= maxd) || (gap <= CW'(cfg.step_size));
		unique case (mode_d)
			MODE_ON: begin
				if (snap) begin
					duty_d = maxd;
					st     = ST_ON;
				end else begin
					duty_d = duty_q + DUTY_BITS'(cfg.step_size);
					st     = ST_RAMP;
				end
			end
			MODE_ERR: begin
				duty_d = '0;
				st     = ST_ERR;
			end
			default: begin
				duty_d = '0;
				st     = ST_OFF;
			end
		endcase
	end

	// Build the result; a running fan with no current reports error
	always_comb begin
		res.pwm_duty    = (mode_d == MODE_ON) ? 8'(duty_d) : 8'd0;
		res.fan_mode    = mode_d;
		res.fan1_status = (mode_d == MODE_ON && cur_zero[0]) ? ST_ERR : st;
		res.fan2_status = (mode_d == MODE_ON && cur_zero[1]) ? ST_ERR : st;
		res.fan3_status = (mode_d == MODE_ON && cur_zero[2]) ? ST_ERR : st;
	end

	// Advance the controller state once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			duty_q <= '0;
		end else if (adv) begin
			mode_q <= mode_d;
			duty_q <= duty_d;
		end
	end

endmodule

@@ sv/fan_ramp_controller_core.sv @@
// Fan ramp controller: fan mode decode and linear PWM duty ramp.
// Pipeline: input register, then result register; the tick update sits
//   between them.
// Throughput: one tick per cycle; the output register stalls only on m_tready.
// Reset (arst_n low): mode off, duty zero, pipeline empty,
//   duty limit 255 and step size 13.
module fan_ramp_controller_core #(
	parameter int DUTY_BITS = frc_pkg::DUTY_BITS_DEF,
	parameter int ADC_BITS  = frc_pkg::ADC_BITS_DEF,
	parameter int IN_W      = ((6 + 3 * ADC_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// vehicle_state[3], requested_state[3], fan1_current, fan2_current,
	// fan3_current[ADC_BITS each], zero pad
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [IN_W-1:0]                 s_tdata,
	// pwm_duty[8], fan_mode[2], fan1_status[2], fan2_status[2], fan3_status[2]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [frc_pkg::RES_W-1:0]       m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [frc_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [frc_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [frc_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import frc_pkg::*;

	localparam int F1_LO = 6;
	localparam int F2_LO = F1_LO + ADC_BITS;
	localparam int F3_LO = F2_LO + ADC_BITS;

	frc_cfg_t    cfg;
	frc_result_t res;

	logic        v_s1;
	logic [2:0]  vs_s1;
	logic [2:0]  rs_s1;
	logic [2:0]  zero_s1;
	logic        v_s2;
	frc_result_t res_s2;
	logic        adv;
	logic        out_free;

	frc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: stage 1 moves on whenever the result register can take it
	assign out_free = !v_s2 || m_tready;
	assign adv      = v_s1 && out_free;
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready)
				v_s1 <= s_tvalid;
			if (out_free)
				v_s2 <= v_s1;
		end
	end

	// Capture the input transfer; only zero-current flags are kept
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			vs_s1      <= s_tdata[2:0];
			rs_s1      <= s_tdata[5:3];
			zero_s1[0] <= (s_tdata[F1_LO +: ADC_BITS] == '0);
			zero_s1[1] <= (s_tdata[F2_LO +: ADC_BITS] == '0);
			zero_s1[2] <= (s_tdata[F3_LO +: ADC_BITS] == '0);
		end
	end

	frc_tick_unit #(
		.DUTY_BITS (DUTY_BITS)
	) u_tick (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.vehicle_state   (vs_s1),
		.requested_state (rs_s1),
		.cur_zero        (zero_s1),
		.cfg             (cfg),
		.res             (res)
	);

	// Hold the result until it is taken
	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = res_s2;

endmodule

@@ sv/frc_checker.sv @@
module frc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [frc_pkg::RES_W-1:0] m_tdata
);
	import frc_pkg::*;

	frc_result_t r;
	assign r = m_tdata;

	// A stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Duty is driven only in on mode
	a_duty_off: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.fan_mode != MODE_ON |-> r.pwm_duty == 8'd0)
		else $error("nonzero duty outside on mode");

	// Error mode flags every fan
	a_err_all: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.fan_mode == MODE_ERR |->
			r.fan1_status == ST_ERR && r.fan2_status == ST_ERR &&
			r.fan3_status == ST_ERR)
		else $error("error mode without fan error status");

	// Off mode reports every fan off
	a_off_all: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.fan_mode == MODE_OFF |->
			r.fan1_status == ST_OFF && r.fan2_status == ST_OFF &&
			r.fan3_status == ST_OFF)
		else $error("off mode with active fan status");

	// Mode code three is never produced
	a_mode_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[9:8] != 2'd3)
		else $error("illegal fan mode code");

endmodule

bind fan_ramp_controller_core frc_checker u_frc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ sim/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import frc_pkg::*;

	localparam int TB_IN_W = 40;
	localparam logic [CFG_ADDR_W-1:0] ADDR_DUTY_LIMIT = {REG_DUTY_LIMIT, 2'b00};
	localparam logic [CFG_ADDR_W-1:0] ADDR_STEP_SIZE  = {REG_STEP_SIZE, 2'b00};
	localparam logic [9:0] CUR_MAX = 10'd1023;

	typedef struct {
		logic [2:0] present;
		logic [2:0] request;
		logic [9:0] cur1;
		logic [9:0] cur2;
		logic [9:0] cur3;
	} fan_tick_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TB_IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [RES_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	// Shadow copy of the block's registers and tick state
	logic [7:0] shadow_duty_limit = DUTY_LIMIT_RST;
	logic [7:0] shadow_step_size = STEP_SIZE_RST;
	fan_mode_t shadow_mode = MODE_OFF;
	logic [7:0] shadow_duty = 8'd0;

	frc_result_t expected_fan_outputs[$];
	int fail_count = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	frc_result_t got_result;
	frc_result_t want_result;

	fan_ramp_controller_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Random backpressure on the result side
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// Advance the shadow state by one tick and return the expected result
	function automatic frc_result_t next_fan_outputs(input fan_tick_t t);
		frc_result_t r;
		fan_status_t st;
		logic run_req;
		run_req = (t.request == VS_HV_ENABLE) || (t.request == VS_READY);
		case (t.present)
			VS_LOW_VOLT: begin
				// any other request in low voltage keeps the mode
				if (t.request == VS_LOW_VOLT)
					shadow_mode = MODE_OFF;
				else if (run_req)
					shadow_mode = MODE_ON;
			end
			VS_HV_ENABLE, VS_READY: shadow_mode = run_req ? MODE_ON : MODE_OFF;
			VS_ERROR: shadow_mode = MODE_ERR;
			default: shadow_mode = MODE_OFF;
		endcase
		case (shadow_mode)
			MODE_ON: begin
				// snap to the maximum once within one step of it
				if (shadow_duty >= shadow_duty_limit ||
						(shadow_duty_limit - shadow_duty) <= shadow_step_size) begin
					shadow_duty = shadow_duty_limit;
					st = ST_ON;
				end else begin
					shadow_duty = shadow_duty + shadow_step_size;
					st = ST_RAMP;
				end
			end
			MODE_ERR: begin
				shadow_duty = 8'd0;
				st = ST_ERR;
			end
			default: begin
				shadow_duty = 8'd0;
				st = ST_OFF;
			end
		endcase
		r.pwm_duty = (shadow_mode == MODE_ON) ? shadow_duty : 8'd0;
		r.fan_mode = shadow_mode;
		r.fan1_status = (shadow_mode == MODE_ON && t.cur1 == 10'd0) ? ST_ERR : st;
		r.fan2_status = (shadow_mode == MODE_ON && t.cur2 == 10'd0) ? ST_ERR : st;
		r.fan3_status = (shadow_mode == MODE_ON && t.cur3 == 10'd0) ? ST_ERR : st;
		return r;
	endfunction

	// Compare each result transfer with the oldest expectation
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_result = m_tdata;
			if (expected_fan_outputs.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_tdata);
				fail_count++;
			end else begin
				want_result = expected_fan_outputs.pop_front();
				if (got_result.pwm_duty !== want_result.pwm_duty) begin
					$error("pwm_duty: expected %0d, got %0d",
						want_result.pwm_duty, got_result.pwm_duty);
					fail_count++;
				end
				if (got_result.fan_mode !== want_result.fan_mode) begin
					$error("fan_mode: expected %0d, got %0d",
						want_result.fan_mode, got_result.fan_mode);
					fail_count++;
				end
				if (got_result.fan1_status !== want_result.fan1_status) begin
					$error("fan1_status: expected %0d, got %0d",
						want_result.fan1_status, got_result.fan1_status);
					fail_count++;
				end
				if (got_result.fan2_status !== want_result.fan2_status) begin
					$error("fan2_status: expected %0d, got %0d",
						want_result.fan2_status, got_result.fan2_status);
					fail_count++;
				end
				if (got_result.fan3_status !== want_result.fan3_status) begin
					$error("fan3_status: expected %0d, got %0d",
						want_result.fan3_status, got_result.fan3_status);
					fail_count++;
				end
			end
		end
	end

	function automatic fan_tick_t make_tick(input logic [2:0] present,
			input logic [2:0] request, input logic [9:0] c1, input logic [9:0] c2,
			input logic [9:0] c3);
		fan_tick_t t;
		t.present = present;
		t.request = request;
		t.cur1 = c1;
		t.cur2 = c2;
		t.cur3 = c3;
		return t;
	endfunction

	// Send one tick; returns at the edge of its transfer with tvalid still high
	task automatic send_tick(input fan_tick_t t);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0000, t.cur3, t.cur2, t.cur1, t.request, t.present};
		do @(negedge clk); while (!s_tready);
		expected_fan_outputs.push_back(next_fan_outputs(t));
		@(posedge clk);
	endtask

	// Drop tvalid and hold until every expected result has arrived
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (expected_fan_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [7:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {24'd0, data};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_DUTY_LIMIT)
			shadow_duty_limit = data;
		else if (addr == ADDR_STEP_SIZE)
			shadow_step_size = data;
	endtask

	// Reprogram both registers once the pipeline is empty
	task automatic set_limits(input logic [7:0] duty_limit, input logic [7:0] step_size);
		wait_for_results();
		apb_write(ADDR_DUTY_LIMIT, duty_limit);
		apb_write(ADDR_STEP_SIZE, step_size);
	endtask

	function automatic logic [9:0] rand_current();
		int k;
		k = $urandom_range(0, 99);
		if (k < 10)
			return 10'd0;
		else if (k < 20)
			return CUR_MAX;
		return 10'($urandom_range(0, 1023));
	endfunction

	// Mode decode over all state pairs of interest, default limits
	task automatic test_mode_decode();
		send_tick(make_tick(VS_LOW_VOLT, VS_LOW_VOLT, CUR_MAX, CUR_MAX, CUR_MAX));
		send_tick(make_tick(VS_LOW_VOLT, VS_ERROR, 10'd0, 10'd0, 10'd0));
		send_tick(make_tick(VS_HV_ENABLE, VS_READY, 10'd0, CUR_MAX, 10'd1));
		send_tick(make_tick(VS_READY, VS_HV_ENABLE, CUR_MAX, 10'd0, CUR_MAX));
		send_tick(make_tick(VS_LOW_VOLT, 3'd6, CUR_MAX, CUR_MAX, 10'd0));
		send_tick(make_tick(VS_LOW_VOLT, VS_LOW_VOLT, 10'd512, 10'd1, 10'd2));
		send_tick(make_tick(VS_LOW_VOLT, VS_READY, 10'd5, 10'd6, 10'd7));
		send_tick(make_tick(VS_ERROR, VS_HV_ENABLE, 10'd0, 10'd0, 10'd0));
		send_tick(make_tick(VS_LOW_VOLT, 3'd7, CUR_MAX, CUR_MAX, CUR_MAX));
		send_tick(make_tick(VS_LOW_VOLT, VS_HV_ENABLE, CUR_MAX, CUR_MAX, CUR_MAX));
		send_tick(make_tick(VS_HV_ENABLE, VS_LOW_VOLT, CUR_MAX, CUR_MAX, CUR_MAX));
		send_tick(make_tick(VS_READY, VS_ERROR, 10'd0, 10'd0, 10'd0));
		send_tick(make_tick(3'd5, VS_READY, CUR_MAX, CUR_MAX, CUR_MAX));
		send_tick(make_tick(3'd7, 3'd7, 10'd0, 10'd0, 10'd0));
		send_tick(make_tick(3'd6, VS_HV_ENABLE, CUR_MAX, CUR_MAX, CUR_MAX));
		wait_for_results();
	endtask

	// Snap to maximum, duty above a lowered maximum, zero step, zero maximum
	task automatic test_ramp_limits();
		set_limits(8'd255, 8'd255);
		send_tick(make_tick(VS_HV_ENABLE, VS_HV_ENABLE, CUR_MAX, CUR_MAX, CUR_MAX));
		set_limits(8'd100, 8'd255);
		send_tick(make_tick(VS_READY, VS_READY, CUR_MAX, 10'd0, CUR_MAX));
		set_limits(8'd200, 8'd0);
		send_tick(make_tick(VS_HV_ENABLE, VS_READY, CUR_MAX, CUR_MAX, CUR_MAX));
		send_tick(make_tick(VS_READY, VS_HV_ENABLE, CUR_MAX, CUR_MAX, 10'd0));
		set_limits(8'd100, 8'd0);
		send_tick(make_tick(VS_READY, VS_READY, CUR_MAX, CUR_MAX, CUR_MAX));
		set_limits(8'd0, 8'd1);
		send_tick(make_tick(VS_HV_ENABLE, VS_HV_ENABLE, 10'd0, 10'd0, 10'd0));
		send_tick(make_tick(VS_ERROR, VS_ERROR, CUR_MAX, CUR_MAX, CUR_MAX));
		wait_for_results();
	endtask

	// Mostly run requests so ramps play out; the rest is arbitrary states
	task automatic test_random_ticks(input int idle_pct, input int stall_pct);
		fan_tick_t t;
		int k;
		src_idle_pct = idle_pct;
		snk_stall_pct = stall_pct;
		for (int seg = 0; seg < 3; seg++) begin
			case (seg)
				0: set_limits(8'd255, 8'($urandom_range(1, 32)));
				1: set_limits(8'($urandom_range(0, 255)), 8'd1);
				default: set_limits(
					$urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 254)),
					$urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(2, 254)));
			endcase
			for (int n = 0; n < 62; n++) begin
				k = $urandom_range(0, 99);
				if (k < 70) begin
					t.present = 3'($urandom_range(1, 2));
					t.request = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 2))
						: 3'($urandom_range(0, 7));
				end else if (k < 85) begin
					t.present = VS_LOW_VOLT;
					t.request = 3'($urandom_range(0, 7));
				end else begin
					t.present = 3'($urandom_range(0, 7));
					t.request = 3'($urandom_range(0, 7));
				end
				t.cur1 = rand_current();
				t.cur2 = rand_current();
				t.cur3 = rand_current();
				send_tick(t);
			end
		end
		wait_for_results();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_mode_decode();
		test_ramp_limits();
		test_random_ticks(0, 0);
		test_random_ticks(56, 0);
		test_random_ticks(0, 56);
		test_random_ticks(23, 23);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		wait_for_results();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/frc_pkg.sv
sv/frc_cfg_regs.sv
sv/frc_tick_unit.sv
sv/fan_ramp_controller_core.sv
sv/frc_checker.sv
sim/tb_top.sv
